// ===== sv/battery_status_aggregator_assert.svh =====
// ----------------------------------------------------------------------------
// Battery status aggregator assertion macros
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_STATUS_AGGREGATOR_ASSERT_SVH
`define BATTERY_STATUS_AGGREGATOR_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("bsa: same-cycle check failed");

// next-cycle implication
`define BSA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("bsa: next-cycle check failed");

`endif

// ===== sv/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery status aggregator package
// Field widths, fixed codes and divider request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int CAP_W   = 32;
  localparam int RATE_W  = 32;
  localparam int STATE_W = 4;
  localparam int RST_W   = 3;
  localparam int PCT_W   = 8;
  localparam int PSUM_W  = 12;
  localparam int SUM_W   = 40;
  localparam int OUT_W   = 41;
  localparam int DIV_W   = 40;
  localparam int ENTRY_W = CAP_W + 1;

  localparam logic [RST_W-1:0]  NOT_PRESENT = 3'd7;
  localparam int                ST_DISCHG   = 0;
  localparam int                ST_CHARGING = 1;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 8'd100;
  localparam logic [PCT_W-1:0]  PCT_UNKNOWN = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
  localparam logic [OUT_W-1:0]  OUT_UNKNOWN = '1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/bsa_in_if.sv =====
// ----------------------------------------------------------------------------
// Battery record channel
// Valid/ready channel carrying one battery status record.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_in_if import bsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fetch_ok;
  logic [STATE_W-1:0] batt_state;
  logic [CAP_W-1:0]   remaining_cap;
  logic [CAP_W-1:0]   voltage;
  logic [RATE_W-1:0]  present_rate;
  logic [CAP_W-1:0]   last_full_capacity;
  logic               selected_unit;
  logic               last_record;

  modport source (
    output valid, fetch_ok, batt_state, remaining_cap, voltage, present_rate,
           last_full_capacity, selected_unit, last_record,
    input  ready
  );

  modport sink (
    input  valid, fetch_ok, batt_state, remaining_cap, voltage, present_rate,
           last_full_capacity, selected_unit, last_record,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/bsa_out_if.sv =====
// ----------------------------------------------------------------------------
// Battery report channel
// Valid/ready channel carrying one battery report.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_out_if import bsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PCT_W-1:0] cap_percent;
  logic signed [OUT_W-1:0] minutes_left;
  logic [RST_W-1:0]        report_state;
  logic signed [OUT_W-1:0] report_rate;
  logic                    error_code;

  modport source (
    output valid, cap_percent, minutes_left, report_state, report_rate, error_code,
    input  ready
  );

  modport sink (
    input  valid, cap_percent, minutes_left, report_state, report_rate, error_code,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/bsa_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_div import bsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] dvs_r;

  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [DIV_W:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        // dividend shifts out at the top while quotient bits enter at the bottom
        rem_r <= rem_nxt;
        q_r   <= {q_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

// ===== sv/bsa_cap_mem.sv =====
// ----------------------------------------------------------------------------
// Capacity store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_cap_mem import bsa_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/battery_status_aggregator.sv =====
// ----------------------------------------------------------------------------
// Battery status aggregator
//
// in_bus carries one status record per battery; a run ends with the record
// marked last_record, after which one report leaves on out_bus. Other records
// give no report. cfg_wr_en/cfg_wr_data set the query mode (aggregate or the
// selected battery); write it only while no run is being reported.
// A valid record passes once through the serial divider for the percentage;
// invalid and dropped records skip it; one record is in work at a time.
// After the last record the report takes the percent average (aggregate
// mode), then one minute division per stored valid battery, skipped for an
// invalid one or when nothing discharges (one battery in single mode), all
// on the same shared divider, and then loads the output register.
// The report sits in an output register; the next run is accepted while it
// waits. If a report is ready while the previous one is still stalled, the
// block holds until out_bus.ready. Reset clears the run state and the query
// mode; the capacity store needs no clearing, as only entries written in the
// current run are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "battery_status_aggregator_assert.svh"

module battery_status_aggregator import bsa_pkg::*; #(
  parameter int MAX_BATTERIES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  bsa_in_if.sink     in_bus,
  bsa_out_if.source  out_bus
);

  localparam int CW = $clog2(MAX_BATTERIES + 1);
  localparam int AW = (MAX_BATTERIES > 1) ? $clog2(MAX_BATTERIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PCT, S_UPD, S_FIN, S_AVG, S_RD, S_MDIV, S_MWAIT, S_EMIT
  } state_t;

  state_t             state_r;
  logic               qs_r;

  // record held during its update
  logic [CAP_W-1:0]   cap_r;
  logic [RST_W-1:0]   st_r;
  logic [RATE_W-1:0]  rate_r;
  logic               sel_r;
  logic               last_r;
  logic               good_r;

  // run state
  logic [CW-1:0]      record_count_r;
  logic [CW-1:0]      valid_count_r;
  logic [PSUM_W-1:0]  percent_sum_r;
  logic [SUM_W-1:0]   rate_sum_r;
  logic [RST_W-1:0]   state_union_r;
  logic               chosen_found_r;
  logic [PCT_W-1:0]   chosen_pct_r;
  logic [RST_W-1:0]   chosen_st_r;
  logic [RATE_W-1:0]  chosen_rate_r;
  logic [AW-1:0]      chosen_idx_r;

  // report pass
  logic [CW-1:0]      idx_r;
  logic [SUM_W-1:0]   total_r;
  logic [PCT_W-1:0]   avg_r;

  logic               out_valid_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic [OUT_W-1:0]   out_mins_r;
  logic [RST_W-1:0]   out_st_r;
  logic [OUT_W-1:0]   out_rate_r;
  logic               out_err_r;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               mem_wr_en;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [ENTRY_W-1:0] mem_rd_data;

  logic               in_accept;
  logic               in_take;
  logic               in_good;
  logic [DIV_W-1:0]   pct_dividend;
  logic [DIV_W-1:0]   min_dividend;
  logic [PCT_W-1:0]   pct_w;
  logic [SUM_W:0]     rate_add;
  logic [SUM_W:0]     total_add;
  logic               ps_neg;
  logic [PSUM_W-1:0]  ps_abs;
  logic [PCT_W-1:0]   avg_q;
  logic [CW-1:0]      idx_inc;
  logic               more_w;
  logic               err_w;
  logic               none_w;
  logic               emit_load;
  logic [OUT_W-1:0]   mins_w;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_accept    = in_bus.valid && in_bus.ready;
  assign in_take      = record_count_r < CW'(MAX_BATTERIES);
  assign in_good      = in_bus.fetch_ok && (in_bus.batt_state < STATE_W'(NOT_PRESENT))
                        && (in_bus.remaining_cap != '1) && (in_bus.voltage != '1)
                        && (in_bus.last_full_capacity != '0);

  // 100*cap by shift and add, 60*cap by shift and subtract
  assign pct_dividend = (DIV_W'(in_bus.remaining_cap) << 6)
                      + (DIV_W'(in_bus.remaining_cap) << 5)
                      + (DIV_W'(in_bus.remaining_cap) << 2);
  assign min_dividend = (DIV_W'(mem_rd_data[CAP_W-1:0]) << 6)
                      - (DIV_W'(mem_rd_data[CAP_W-1:0]) << 2);

  assign pct_w     = !good_r ? PCT_UNKNOWN :
                     (div_rsp.quotient > DIV_W'(PCT_FULL)) ? PCT_FULL :
                     div_rsp.quotient[PCT_W-1:0];
  assign rate_add  = {1'b0, rate_sum_r} + (SUM_W + 1)'(rate_r);
  assign total_add = {1'b0, total_r} + {1'b0, div_rsp.quotient};
  assign ps_neg    = percent_sum_r[PSUM_W-1];
  assign ps_abs    = ps_neg ? (PSUM_W'(0) - percent_sum_r) : percent_sum_r;
  assign avg_q     = div_rsp.quotient[PCT_W-1:0];
  assign idx_inc   = idx_r + CW'(1);
  assign more_w    = !qs_r && (idx_inc < record_count_r);
  assign err_w     = qs_r && !chosen_found_r;
  assign none_w    = err_w || (valid_count_r == '0);
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_bus.ready);

  always_comb begin
    if (rate_sum_r == '0) begin
      mins_w = OUT_UNKNOWN;
    end else if (qs_r ? chosen_st_r[ST_CHARGING] : state_union_r[ST_CHARGING]) begin
      mins_w = OUT_UNKNOWN;
    end else begin
      mins_w = {1'b0, total_r};
    end
  end

  // shared divider: record percentage, percent average, minutes per battery
  always_comb begin
    div_req = '0;
    case (state_r)
      S_IDLE: begin
        div_req.start    = in_accept && in_take && in_good;
        div_req.dividend = pct_dividend;
        div_req.divisor  = DIV_W'(in_bus.last_full_capacity);
      end
      S_FIN: begin
        div_req.start    = !none_w && !qs_r;
        div_req.dividend = DIV_W'(ps_abs);
        div_req.divisor  = DIV_W'(valid_count_r);
      end
      S_MDIV: begin
        div_req.start    = mem_rd_data[CAP_W] && (rate_sum_r != '0);
        div_req.dividend = min_dividend;
        div_req.divisor  = DIV_W'(rate_sum_r);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  assign mem_wr_en   = (state_r == S_UPD);
  assign mem_wr_data = good_r ? {1'b1, cap_r} : '0;
  assign mem_rd_en   = (state_r == S_RD);

  bsa_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  bsa_cap_mem #(
    .DEPTH (MAX_BATTERIES),
    .AW    (AW)
  ) u_cap_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (record_count_r[AW-1:0]),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      qs_r           <= 1'b0;
      record_count_r <= '0;
      valid_count_r  <= '0;
      percent_sum_r  <= '0;
      rate_sum_r     <= '0;
      state_union_r  <= '0;
      chosen_found_r <= 1'b0;
      chosen_pct_r   <= PCT_UNKNOWN;
      chosen_st_r    <= NOT_PRESENT;
      chosen_rate_r  <= '0;
      chosen_idx_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        qs_r <= cfg_wr_data;
      end
      if (out_valid_r && out_bus.ready && !emit_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            cap_r  <= in_bus.remaining_cap;
            st_r   <= in_bus.batt_state[RST_W-1:0];
            rate_r <= in_bus.present_rate;
            sel_r  <= in_bus.selected_unit;
            last_r <= in_bus.last_record;
            good_r <= in_good;
            if (in_take) begin
              state_r <= in_good ? S_PCT : S_UPD;
            end else if (in_bus.last_record) begin
              state_r <= S_FIN;
            end
          end
        end
        S_PCT: begin
          if (div_rsp.done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          percent_sum_r <= percent_sum_r + {{(PSUM_W-PCT_W){pct_w[PCT_W-1]}}, pct_w};
          if (good_r) begin
            valid_count_r <= valid_count_r + CW'(1);
            state_union_r <= state_union_r | st_r;
            if (st_r[ST_DISCHG] && (rate_r != '0)) begin
              rate_sum_r <= rate_add[SUM_W] ? SUM_MAX : rate_add[SUM_W-1:0];
            end
          end
          if (qs_r && sel_r) begin
            chosen_found_r <= 1'b1;
            chosen_pct_r   <= pct_w;
            chosen_st_r    <= good_r ? st_r : NOT_PRESENT;
            chosen_rate_r  <= rate_r;
            chosen_idx_r   <= record_count_r[AW-1:0];
          end
          record_count_r <= record_count_r + CW'(1);
          state_r        <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          total_r <= '0;
          idx_r   <= qs_r ? CW'(chosen_idx_r) : '0;
          if (none_w) begin
            state_r <= S_EMIT;
          end else if (qs_r) begin
            state_r <= S_RD;
          end else begin
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_rsp.done) begin
            // magnitude was divided; negating restores the sign, so the result truncates toward zero
            avg_r   <= ps_neg ? (PCT_W'(0) - avg_q) : avg_q;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MDIV;
        end
        S_MDIV: begin
          if (div_req.start) begin
            state_r <= S_MWAIT;
          end else if (more_w) begin
            idx_r   <= idx_inc;
            state_r <= S_RD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_MWAIT: begin
          if (div_rsp.done) begin
            total_r <= total_add[SUM_W] ? SUM_MAX : total_add[SUM_W-1:0];
            if (more_w) begin
              idx_r   <= idx_inc;
              state_r <= S_RD;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid_r <= 1'b1;
            out_err_r   <= err_w;
            if (none_w) begin
              out_pct_r  <= PCT_UNKNOWN;
              out_mins_r <= OUT_UNKNOWN;
              out_st_r   <= NOT_PRESENT;
              out_rate_r <= OUT_UNKNOWN;
            end else if (qs_r) begin
              out_pct_r  <= chosen_pct_r;
              out_mins_r <= mins_w;
              out_st_r   <= chosen_st_r;
              out_rate_r <= OUT_W'(chosen_rate_r);
            end else begin
              out_pct_r  <= avg_r;
              out_mins_r <= mins_w;
              out_st_r   <= state_union_r;
              out_rate_r <= {1'b0, rate_sum_r};
            end
            record_count_r <= '0;
            valid_count_r  <= '0;
            percent_sum_r  <= '0;
            rate_sum_r     <= '0;
            state_union_r  <= '0;
            chosen_found_r <= 1'b0;
            chosen_pct_r   <= PCT_UNKNOWN;
            chosen_st_r    <= NOT_PRESENT;
            chosen_rate_r  <= '0;
            chosen_idx_r   <= '0;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.cap_percent  = out_pct_r;
  assign out_bus.minutes_left = out_mins_r;
  assign out_bus.report_state = out_st_r;
  assign out_bus.report_rate  = out_rate_r;
  assign out_bus.error_code   = out_err_r;

  `BSA_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
  `BSA_ASSERT_IMP(a_store_in_range, clk, rst_n, mem_wr_en, record_count_r < CW'(MAX_BATTERIES))
  `BSA_ASSERT_IMP(a_read_written, clk, rst_n, mem_rd_en, idx_r < record_count_r)
  `BSA_ASSERT_IMP(a_valid_le_records, clk, rst_n, 1'b1, valid_count_r <= record_count_r)
  `BSA_ASSERT_NXT(a_run_cleared, clk, rst_n, emit_load, record_count_r == '0 && !chosen_found_r)

endmodule

`default_nettype wire

// ===== sim/tb_battery_status_aggregator.sv =====
// ----------------------------------------------------------------------------
// Battery status aggregator testbench
// Drives runs of battery records through the valid/ready record channel in
// both query modes, predicts each report with a behavioural model of the
// aggregator and compares every report field by field. Directed runs hit the
// clamps, invalid records, dropped records and selection rules; random runs
// follow, with bursts of idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_battery_status_aggregator;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int SLOTS       = 8;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYC  = 100;
  localparam int DRAIN_CYC   = 200;
  localparam int HOLD_CYC    = 1500;

  localparam logic MODE_AGGR   = 1'b0;
  localparam logic MODE_SINGLE = 1'b1;

  localparam logic [STATE_W-1:0] BS_NONE     = 4'd0;
  localparam logic [STATE_W-1:0] BS_DIS      = 4'd1;
  localparam logic [STATE_W-1:0] BS_CHG      = 4'd2;
  localparam logic [STATE_W-1:0] BS_CRIT_DIS = 4'd5;
  localparam logic [STATE_W-1:0] BS_ABSENT   = 4'd7;
  localparam logic [STATE_W-1:0] BS_ALL      = 4'd15;

  localparam logic [CAP_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic               fetch_ok;
    logic [STATE_W-1:0] batt_state;
    logic [CAP_W-1:0]   remaining_cap;
    logic [CAP_W-1:0]   voltage;
    logic [RATE_W-1:0]  present_rate;
    logic [CAP_W-1:0]   last_full_capacity;
    logic               selected_unit;
    logic               last_record;
  } batt_rec_t;

  typedef struct packed {
    logic signed [PCT_W-1:0] cap_percent;
    logic signed [OUT_W-1:0] minutes_left;
    logic [RST_W-1:0]        report_state;
    logic signed [OUT_W-1:0] report_rate;
    logic                    error_code;
  } batt_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  bsa_in_if  in_bus();
  bsa_out_if out_bus();

  battery_status_aggregator #(.MAX_BATTERIES(SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_bus),
    .out_bus     (out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run state of the model
  logic                    mode_single;
  logic                    slot_ok  [SLOTS];
  logic [CAP_W-1:0]        slot_cap [SLOTS];
  int                      n_rec;
  int                      n_valid;
  int                      pct_total;
  logic [SUM_W-1:0]        dis_rate;
  logic [RST_W-1:0]        state_or;
  logic                    sel_seen;
  logic signed [PCT_W-1:0] sel_pct;
  logic [RST_W-1:0]        sel_state;
  logic [RATE_W-1:0]       sel_rate;
  int                      sel_slot;

  batt_report_t report_q[$];
  int           fail_cnt  = 0;
  bit           idle_on   = 1'b1;
  int           hold_left = 0;
  longint       cycle_cnt = 0;

  function automatic void clear_run();
    n_rec     = 0;
    n_valid   = 0;
    pct_total = 0;
    dis_rate  = '0;
    state_or  = '0;
    sel_seen  = 1'b0;
    sel_pct   = PCT_UNKNOWN;
    sel_state = NOT_PRESENT;
    sel_rate  = '0;
    sel_slot  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_ok[i]  = 1'b0;
      slot_cap[i] = '0;
    end
  endfunction

  function automatic logic [SUM_W-1:0] slot_minutes(input int i);
    if (!slot_ok[i] || dis_rate == '0) return '0;
    return SUM_W'((64'd60 * slot_cap[i]) / dis_rate);
  endfunction

  // Folds one accepted record into the run; returns 1 with the report on the
  // record that ends the run.
  function automatic bit absorb_record(input batt_rec_t r, output batt_report_t rep);
    logic                    ok;
    logic [63:0]             ratio;
    logic [63:0]             total;
    logic signed [PCT_W-1:0] pct;
    logic [RST_W-1:0]        st;
    logic [SUM_W:0]          wide;
    rep = '0;
    if (n_rec < SLOTS) begin
      ok = r.fetch_ok && r.batt_state < {1'b0, NOT_PRESENT} &&
           r.remaining_cap != ALL_ONES && r.voltage != ALL_ONES &&
           r.last_full_capacity != '0;
      pct = PCT_UNKNOWN;
      st  = NOT_PRESENT;
      if (ok) begin
        ratio = (64'd100 * r.remaining_cap) / r.last_full_capacity;
        pct   = (ratio > PCT_FULL) ? PCT_FULL : PCT_W'(ratio);
        st    = r.batt_state[RST_W-1:0];
        n_valid++;
        state_or |= st;
        if (r.present_rate != '0 && st[ST_DISCHG]) begin
          wide     = dis_rate + r.present_rate;
          dis_rate = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
        end
        slot_ok[n_rec]  = 1'b1;
        slot_cap[n_rec] = r.remaining_cap;
      end else begin
        slot_ok[n_rec]  = 1'b0;
        slot_cap[n_rec] = '0;
      end
      // invalid batteries pull the sum down by one each
      pct_total += pct;
      if (mode_single && r.selected_unit) begin
        sel_seen  = 1'b1;
        sel_pct   = pct;
        sel_state = st;
        sel_rate  = r.present_rate;
        sel_slot  = n_rec;
      end
      n_rec++;
    end
    if (!r.last_record) return 1'b0;

    if (mode_single && !sel_seen) begin
      rep = '{PCT_UNKNOWN, OUT_UNKNOWN, NOT_PRESENT, OUT_UNKNOWN, 1'b1};
    end else if (n_valid == 0) begin
      rep = '{PCT_UNKNOWN, OUT_UNKNOWN, NOT_PRESENT, OUT_UNKNOWN, 1'b0};
    end else if (!mode_single) begin
      total = '0;
      for (int i = 0; i < n_rec; i++) begin
        total += slot_minutes(i);
        if (total > SUM_MAX) total = SUM_MAX;
      end
      rep.cap_percent  = PCT_W'(pct_total / n_valid);
      rep.minutes_left = (dis_rate == '0 || state_or[ST_CHARGING]) ? OUT_UNKNOWN
                                                                   : OUT_W'(total);
      rep.report_state = state_or;
      rep.report_rate  = {1'b0, dis_rate};
    end else begin
      rep.cap_percent  = sel_pct;
      rep.minutes_left = (dis_rate == '0 || sel_state[ST_CHARGING]) ? OUT_UNKNOWN
                                                                    : {1'b0, slot_minutes(sel_slot)};
      rep.report_state = sel_state;
      rep.report_rate  = OUT_W'(sel_rate);
    end
    clear_run();
    return 1'b1;
  endfunction

  function automatic logic [CAP_W-1:0] rand_magnitude();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CAP_W'($urandom_range(1, 16));
      2:       return CAP_W'($urandom_range(1, 100000));
      3:       return ALL_ONES - CAP_W'($urandom_range(0, 3));
      4:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic batt_rec_t rand_record(input logic last);
    batt_rec_t r;
    r.fetch_ok   = 1'b1;
    r.batt_state = STATE_W'($urandom_range(0, 6));
    // bias towards discharging so the rate sum is mostly nonzero
    if ($urandom_range(0, 2) != 0) begin
      r.batt_state[ST_DISCHG]   = 1'b1;
      r.batt_state[ST_CHARGING] = ($urandom_range(0, 7) == 0);
    end
    r.last_full_capacity = rand_magnitude();
    if (r.last_full_capacity == '0) r.last_full_capacity = CAP_W'($urandom_range(1, 1000));
    if ($urandom_range(0, 2) == 0)
      r.remaining_cap = CAP_W'((64'(r.last_full_capacity) * $urandom_range(0, 120)) / PCT_FULL);
    else
      r.remaining_cap = rand_magnitude();
    if (r.remaining_cap == ALL_ONES) r.remaining_cap = ALL_ONES - 1;
    r.voltage = $urandom;
    if (r.voltage == ALL_ONES) r.voltage = '0;
    r.present_rate  = rand_magnitude();
    r.selected_unit = ($urandom_range(0, 2) == 0);
    r.last_record   = last;
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 4))
        0:       r.fetch_ok           = 1'b0;
        1:       r.batt_state         = STATE_W'($urandom_range(7, 15));
        2:       r.remaining_cap      = ALL_ONES;
        3:       r.voltage            = ALL_ONES;
        default: r.last_full_capacity = '0;
      endcase
    end
    return r;
  endfunction

  task automatic send_record(input batt_rec_t r);
    batt_report_t rep;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.fetch_ok           <= r.fetch_ok;
    in_bus.batt_state         <= r.batt_state;
    in_bus.remaining_cap      <= r.remaining_cap;
    in_bus.voltage            <= r.voltage;
    in_bus.present_rate       <= r.present_rate;
    in_bus.last_full_capacity <= r.last_full_capacity;
    in_bus.selected_unit      <= r.selected_unit;
    in_bus.last_record        <= r.last_record;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (absorb_record(r, rep)) report_q.push_back(rep);
  endtask

  // must be called in the step of the last accepted transaction
  task automatic wait_reports();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_query_mode(input logic mode);
    wait_reports();
    // a dropped or non-final record may still be in work
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mode_single = mode;
  endtask

  task automatic random_runs(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0)      len = $urandom_range(SLOTS + 1, SLOTS + 4);
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(5, SLOTS);
      else                                len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) send_record(rand_record(k == len - 1));
      sent += len;
      if ($urandom_range(0, 29) == 0) set_query_mode($urandom_range(0, 1));
    end
  endtask

  task automatic test_directed_aggregate();
    set_query_mode(MODE_AGGR);
    // percentage clamp
    send_record('{1'b1, BS_DIS, 32'd200, 32'd12000, 32'd50, 32'd100, 1'b0, 1'b1});
    // every kind of invalid record, none valid
    send_record('{1'b0, BS_DIS, 32'd100, 32'd12000, 32'd10, 32'd1000, 1'b0, 1'b0});
    send_record('{1'b1, BS_ABSENT, 32'd100, 32'd12000, 32'd10, 32'd1000, 1'b0, 1'b0});
    send_record('{1'b1, BS_ALL, 32'd100, 32'd12000, 32'd10, 32'd1000, 1'b0, 1'b0});
    send_record('{1'b1, BS_DIS, ALL_ONES, 32'd12000, 32'd10, 32'd1000, 1'b0, 1'b0});
    send_record('{1'b1, BS_DIS, 32'd100, ALL_ONES, 32'd10, 32'd1000, 1'b0, 1'b0});
    send_record('{1'b1, BS_DIS, 32'd100, 32'd12000, 32'd10, 32'd0, 1'b1, 1'b1});
    // minute sum saturates; two records past the store are dropped
    for (int k = 0; k < SLOTS + 2; k++)
      send_record('{1'b1, BS_DIS, ALL_ONES - 1, 32'd0, (k == 0) ? 32'd1 : 32'd0,
                    ALL_ONES, (k == SLOTS), (k == SLOTS + 1)});
    // charging in the union, maximum rate
    send_record('{1'b1, BS_CHG, 32'd0, 32'd11000, 32'd7, 32'd1000, 1'b0, 1'b0});
    send_record('{1'b1, BS_CRIT_DIS, 32'd500, 32'd11000, ALL_ONES, 32'd1000, 1'b1, 1'b1});
  endtask

  task automatic test_directed_single();
    set_query_mode(MODE_SINGLE);
    // nothing selected
    send_record('{1'b1, BS_DIS, 32'd300, 32'd12000, 32'd20, 32'd1000, 1'b0, 1'b1});
    // later invalid selection wins
    send_record('{1'b1, BS_DIS, 32'd300, 32'd12000, 32'd20, 32'd1000, 1'b1, 1'b0});
    send_record('{1'b1, BS_ABSENT, 32'd300, 32'd12000, 32'd20, 32'd1000, 1'b1, 1'b1});
    // selected battery with no discharge rate
    send_record('{1'b1, BS_ABSENT, 32'd300, 32'd12000, 32'd20, 32'd1000, 1'b1, 1'b0});
    send_record('{1'b1, BS_NONE, 32'd0, 32'd12000, 32'd0, 32'd1, 1'b1, 1'b1});
    // selected battery with real minutes
    send_record('{1'b1, BS_DIS, 32'd100, 32'd12000, 32'd40, 32'd100, 1'b0, 1'b0});
    send_record('{1'b1, BS_CRIT_DIS, 32'd1000, 32'd12000, 32'd20, 32'd2000, 1'b1, 1'b1});
  endtask

  task automatic test_random_mixed();
    set_query_mode(MODE_AGGR);
    random_runs(1300);
  endtask

  task automatic test_receiver_hold();
    set_query_mode(MODE_AGGR);
    hold_left = HOLD_CYC;
    // short runs pile up behind the stalled report register
    for (int k = 0; k < 25; k++) send_record(rand_record(1'b1));
  endtask

  task automatic test_sender_pause();
    set_query_mode(MODE_SINGLE);
    random_runs(150);
    wait_reports();
    random_runs(150);
  endtask

  task automatic test_no_idle();
    set_query_mode(MODE_AGGR);
    idle_on = 1'b0;
    random_runs(250);
  endtask

  // report checker and receiver ready
  initial begin : report_sink
    int           stall;
    batt_report_t exp_rep;
    stall = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (report_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: report transaction with none expected", $time);
        end else begin
          exp_rep = report_q.pop_front();
          if (out_bus.cap_percent !== exp_rep.cap_percent) begin
            fail_cnt++;
            $display("%0t: cap_percent expected %0d got %0d", $time,
                     exp_rep.cap_percent, out_bus.cap_percent);
          end
          if (out_bus.minutes_left !== exp_rep.minutes_left) begin
            fail_cnt++;
            $display("%0t: minutes_left expected %0d got %0d", $time,
                     exp_rep.minutes_left, out_bus.minutes_left);
          end
          if (out_bus.report_state !== exp_rep.report_state) begin
            fail_cnt++;
            $display("%0t: report_state expected %0d got %0d", $time,
                     exp_rep.report_state, out_bus.report_state);
          end
          if (out_bus.report_rate !== exp_rep.report_rate) begin
            fail_cnt++;
            $display("%0t: report_rate expected %0d got %0d", $time,
                     exp_rep.report_rate, out_bus.report_rate);
          end
          if (out_bus.error_code !== exp_rep.error_code) begin
            fail_cnt++;
            $display("%0t: error_code expected %0d got %0d", $time,
                     exp_rep.error_code, out_bus.error_code);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n                     <= 1'b0;
    cfg_wr_en                 <= 1'b0;
    cfg_wr_data               <= 1'b0;
    in_bus.valid              <= 1'b0;
    in_bus.fetch_ok           <= 1'b0;
    in_bus.batt_state         <= '0;
    in_bus.remaining_cap      <= '0;
    in_bus.voltage            <= '0;
    in_bus.present_rate       <= '0;
    in_bus.last_full_capacity <= '0;
    in_bus.selected_unit      <= 1'b0;
    in_bus.last_record        <= 1'b0;
    mode_single = MODE_AGGR;
    clear_run();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_aggregate();
    test_directed_single();
    test_random_mixed();
    test_receiver_hold();
    test_sender_pause();
    test_no_idle();

    wait_reports();
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bsa_pkg.sv
sv/bsa_in_if.sv
sv/bsa_out_if.sv
sv/bsa_div.sv
sv/bsa_cap_mem.sv
sv/battery_status_aggregator.sv
sim/tb_battery_status_aggregator.sv
